### src/pbsp_pkg.sv
// ----------------------------------------------------------------------------
// pbsp_pkg: shared types and codes of the packet buffer slot pool
// Request and status codes, field widths and the request token that walks
// the chain of slot cells, and the finished result item.
// ----------------------------------------------------------------------------
package pbsp_pkg;

  // Widths of the item fields.
  localparam int unsigned OpW    = 2;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned StatW  = 2;

  // Largest number of slots that a 6-bit slot index can reach.
  localparam int unsigned MaxCells = 64;

  // Request codes.
  localparam logic [OpW-1:0] OpAlloc   = 2'd0;
  localparam logic [OpW-1:0] OpRelease = 2'd1;
  localparam logic [OpW-1:0] OpCheck   = 2'd2;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    StOk      = 2'd0,
    StEmpty   = 2'd1,
    StDouble  = 2'd2,
    StUnknown = 2'd3
  } status_e;

  // Request token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [OpW-1:0]    op;
    logic [IdxW-1:0]   idx;
    logic [CountW-1:0] lim;
    logic              known;    // idx lies below the active count
    logic              hit;      // a cell has served the request
    logic              bit_seen; // in-use bit of the addressed slot
    logic [IdxW-1:0]   granted;
  } token_t;

  // One finished result item.
  typedef struct packed {
    status_e           status;
    logic [IdxW-1:0]   granted;
    logic              slot_valid;
    logic [CountW-1:0] free_cnt;
    logic [CountW-1:0] alloc_cnt;
  } result_t;

endpackage

### src/pbsp_cell.sv
// ----------------------------------------------------------------------------
// pbsp_cell: one slot of the pool
// Holds the in-use bit of its slot, serves the request token when it passes
// and hands the token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module pbsp_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pbsp_pkg::token_t tok_i,
  output pbsp_pkg::token_t tok_o
);

  localparam logic [pbsp_pkg::IdxW-1:0] Here = pbsp_pkg::IdxW'(CELL_IDX);

  logic             in_use_q, in_use_d;
  pbsp_pkg::token_t tok_q, tok_d;
  logic             below_lim;
  logic             addressed;

  // This slot lies below the active count carried by the token.
  assign below_lim = {1'b0, Here} < tok_i.lim;
  assign addressed = tok_i.valid && tok_i.known && (tok_i.idx == Here);

  // Serve the passing request.
  always_comb begin
    in_use_d = in_use_q;
    tok_d    = tok_i;
    if (tok_i.valid) begin
      case (tok_i.op)
        pbsp_pkg::OpAlloc: begin
          if (!tok_i.hit && !in_use_q && below_lim) begin
            in_use_d      = 1'b1;
            tok_d.hit     = 1'b1;
            tok_d.granted = Here;
          end
        end
        pbsp_pkg::OpRelease: begin
          if (addressed) begin
            tok_d.hit      = 1'b1;
            tok_d.bit_seen = in_use_q;
            in_use_d       = 1'b0;
          end
        end
        pbsp_pkg::OpCheck: begin
          if (addressed) begin
            tok_d.hit      = 1'b1;
            tok_d.bit_seen = in_use_q;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  // Slot state and token stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 1'b0;
      tok_q    <= '0;
    end else begin
      in_use_q <= in_use_d;
      tok_q    <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### src/packet_buffer_slot_pool_unit.sv
// ----------------------------------------------------------------------------
// packet_buffer_slot_pool_unit: fixed pool of packet buffer slots
// Grants, releases and checks buffer slots and keeps the allocated count.
// ----------------------------------------------------------------------------
// Usage:
// A request item enters on the s_axis group: tuser carries the opcode
// (allocate, release, check) and tdata the slot index. One result item
// leaves on the m_axis group with status, granted slot, check flag and the
// free and allocated counts after the request.
// The request travels as a token through a row of cells, one cell per slot,
// advancing one cell each cycle; each cell owns the in-use bit of its slot.
// With C = min(NUM_SLOTS, 64) cells, a finished token leaves the last cell
// and its result passes through the hold and output registers; a new
// request is taken only once the last one has left the row and the hold
// register is empty.
// A finished result waits in the output register while the next request
// walks the row; if the receiver still stalls when that request finishes,
// it waits in a hold register and no further request is taken.
// The active slot count is written over the APB port at address 0; the user
// must do so only while the block is idle, which the block does not enforce.
// Reset frees every slot, clears both counts and empties the pipeline.
// ----------------------------------------------------------------------------
module packet_buffer_slot_pool_unit #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [5:0] slot_index, [7:6] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [1:0] status, [7:2] granted_slot,
                                     // [8] slot_valid, [15:9] free_slots,
                                     // [22:16] allocated_slots, [23] zero
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned Cells =
    (NUM_SLOTS < pbsp_pkg::MaxCells) ? NUM_SLOTS : pbsp_pkg::MaxCells;
  localparam logic [pbsp_pkg::CountW-1:0] CellsCnt = pbsp_pkg::CountW'(Cells);

  logic [pbsp_pkg::CountW-1:0] active_q;
  logic [pbsp_pkg::CountW-1:0] alloc_cnt_q, alloc_cnt_d;
  logic [pbsp_pkg::CountW-1:0] lim;
  logic                        busy_q;
  logic                        hold_v_q;
  pbsp_pkg::result_t           hold_q, hold_d;
  logic                        out_v_q;
  pbsp_pkg::result_t           out_q;
  logic                        in_acc;
  logic                        out_load;
  pbsp_pkg::token_t            tok_in;
  pbsp_pkg::token_t            tok [Cells+1];
  pbsp_pkg::token_t            tail;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      active_q <= pwdata[pbsp_pkg::CountW-1:0];
    end
  end
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, active_q} : 32'd0;

  // Effective number of slots.
  assign lim = (active_q > CellsCnt) ? CellsCnt : active_q;

  // Request intake: the token enters the first cell.
  assign s_axis_tready = !busy_q && !hold_v_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    tok_in          = '0;
    tok_in.valid    = in_acc;
    tok_in.op       = s_axis_tuser;
    tok_in.idx      = s_axis_tdata[pbsp_pkg::IdxW-1:0];
    tok_in.lim      = lim;
    tok_in.known    = {1'b0, s_axis_tdata[pbsp_pkg::IdxW-1:0]} < lim;
  end

  assign tok[0] = tok_in;

  // Row of slot cells.
  for (genvar k = 0; k < Cells; k++) begin : g_cell
    pbsp_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[k]),
      .tok_o (tok[k+1])
    );
  end

  assign tail = tok[Cells];

  // Turn the finished token into a result and update the allocated count.
  always_comb begin
    alloc_cnt_d       = alloc_cnt_q;
    hold_d            = '0;
    hold_d.status     = pbsp_pkg::StOk;
    case (tail.op)
      pbsp_pkg::OpAlloc: begin
        if (tail.hit) begin
          hold_d.granted = tail.granted;
          alloc_cnt_d    = alloc_cnt_q + 7'd1;
        end else begin
          hold_d.status = pbsp_pkg::StEmpty;
        end
      end
      pbsp_pkg::OpRelease: begin
        if (!tail.known) begin
          hold_d.status = pbsp_pkg::StUnknown;
        end else if (tail.bit_seen) begin
          alloc_cnt_d = alloc_cnt_q - 7'd1;
        end else begin
          hold_d.status = pbsp_pkg::StDouble;
        end
      end
      pbsp_pkg::OpCheck: begin
        if (!tail.known) begin
          hold_d.status = pbsp_pkg::StUnknown;
        end else begin
          hold_d.slot_valid = tail.bit_seen;
        end
      end
      default: begin
        hold_d.status = pbsp_pkg::StOk;
      end
    endcase
    hold_d.alloc_cnt = alloc_cnt_d;
    hold_d.free_cnt  = (tail.lim > alloc_cnt_d) ? (tail.lim - alloc_cnt_d) : '0;
  end

  // Output register loads from the hold register when free or drained.
  assign out_load = hold_v_q && (!out_v_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      hold_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
      alloc_cnt_q <= '0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (tail.valid) begin
        busy_q <= 1'b0;
      end
      if (tail.valid) begin
        hold_v_q    <= 1'b1;
        alloc_cnt_q <= alloc_cnt_d;
      end else if (out_load) begin
        hold_v_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (tail.valid) begin
      hold_q <= hold_d;
    end
    if (out_load) begin
      out_q <= hold_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_q.alloc_cnt, out_q.free_cnt, out_q.slot_valid,
                          out_q.granted, out_q.status};

endmodule
